/* rtl/core/hdu_pkg.sv */
// Shared types and constants for the haversine distance pipeline.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package hdu_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_WIDTH = 34;
   localparam int ANGLE_WIDTH  = 26;
   localparam int ROOT_WIDTH   = 31;

   typedef logic signed [CORDIC_WIDTH-1:0] cordic_type;
   typedef logic signed [ANGLE_WIDTH-1:0]  angle_type;
   typedef logic [31:0]                    phase_type;
   typedef logic [ROOT_WIDTH-1:0]          root_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

   localparam cordic_type CORDIC_GAIN = 34'sh26DD3B6A;
   localparam cordic_type ONE_Q30     = 34'sh40000000;
   localparam root_type   UNIT_Q30    = 31'h40000000;

   localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
      30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
      30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
      30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
      30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
   };

endpackage

`default_nettype wire

/* rtl/core/hdu_phase.sv */
// Converts a fixed-point angle in degrees (or its half) to a 32-bit binary phase.
// Divides by the period through four radix-2^16 reciprocal steps; uses hdu_pkg.
`default_nettype none

module hdu_phase #(
   parameter int FRAC_BITS  = 16,
   parameter bit HALF_ANGLE = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hdu_pkg::stage_ctl_type in_ctl,
   input  hdu_pkg::angle_type     angle,
   output logic                  out_valid,
   output hdu_pkg::phase_type     phase
);
   import hdu_pkg::*;

   localparam int          SHIFT       = 32 - FRAC_BITS;
   localparam int          DIV_SHIFT   = 3 + int'(HALF_ANGLE);
   localparam logic [63:0] HALF_PERIOD = 64'd180 << HALF_ANGLE;
   localparam logic [63:0] BIAS        = 64'd45 << 48;
   localparam int          CHUNKS      = 4;
   localparam int          CHUNK_WIDTH = 16;
   localparam logic [21:0] DIVISOR     = 22'd45;
   localparam logic [38:0] RECIP       = 39'd93206;

   logic signed [63:0] wide_v;
   logic signed [63:0] scaled_v;
   logic signed [63:0] floor_v;
   logic [63:0]        biased_v;

   logic [63:0] num_ff   [0:CHUNKS];
   logic [5:0]  rem_ff   [0:CHUNKS];
   logic [31:0] quo_ff   [0:CHUNKS];
   logic        valid_ff [0:CHUNKS];

   // The period is 45 times a power of two, so the power is an arithmetic shift
   // and a bias that is a multiple of 45 * 2^32 keeps the dividend positive.
   assign wide_v   = 64'(angle);
   assign scaled_v = (wide_v <<< SHIFT) + $signed(HALF_PERIOD);
   assign floor_v  = scaled_v >>> DIV_SHIFT;
   assign biased_v = $unsigned(floor_v) + BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[0] <= in_ctl.valid;
      end
      if (in_ctl.advance) begin
         num_ff[0] <= biased_v;
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= CHUNKS; k++) begin : g_div
      localparam int LSB = CHUNK_WIDTH * (CHUNKS - k);
      logic [21:0] dividend;
      logic [38:0] product;
      logic [15:0] q_est;
      logic [21:0] r_wide;
      logic [6:0]  r_est;
      logic [15:0] q_fix;
      logic [6:0]  r_fix;

      assign dividend = {rem_ff[k-1], num_ff[k-1][LSB +: CHUNK_WIDTH]};
      assign product  = 39'(dividend) * RECIP;
      assign q_est    = product[37:22];
      assign r_wide   = dividend - 22'(q_est) * DIVISOR;
      assign r_est    = r_wide[6:0];

      always_comb begin
         if (r_est >= DIVISOR[6:0]) begin
            q_fix = q_est + 16'd1;
            r_fix = r_est - DIVISOR[6:0];
         end else begin
            q_fix = q_est;
            r_fix = r_est;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (in_ctl.advance) begin
            num_ff[k] <= num_ff[k-1];
            rem_ff[k] <= r_fix[5:0];
            quo_ff[k] <= {quo_ff[k-1][15:0], q_fix};
         end
      end
   end

   assign phase     = quo_ff[CHUNKS];
   assign out_valid = valid_ff[CHUNKS];

endmodule

`default_nettype wire

/* rtl/core/hdu_sincos.sv */
// Rotation CORDIC giving Q30 sine and cosine of a 32-bit phase.
// One micro-rotation per register stage after quadrant folding; uses hdu_pkg.
`default_nettype none

module hdu_sincos (
   input  logic                  clock,
   input  logic                  reset,
   input  hdu_pkg::stage_ctl_type in_ctl,
   input  hdu_pkg::phase_type     phase,
   output logic                  out_valid,
   output hdu_pkg::cordic_type    sin_value,
   output hdu_pkg::cordic_type    cos_value
);
   import hdu_pkg::*;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quad_type;

   logic [31:0] biased_v;
   logic [31:0] residual_v;
   quad_type    quad_v;

   cordic_type x_ff     [0:CORDIC_STEPS];
   cordic_type y_ff     [0:CORDIC_STEPS];
   cordic_type z_ff     [0:CORDIC_STEPS];
   quad_type   quad_ff  [0:CORDIC_STEPS];
   logic       valid_ff [0:CORDIC_STEPS+1];
   cordic_type sin_ff;
   cordic_type cos_ff;

   assign biased_v   = phase + 32'h2000_0000;
   assign quad_v     = quad_type'(biased_v[31:30]);
   assign residual_v = phase - {biased_v[31:30], 30'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[0] <= in_ctl.valid;
      end
      if (in_ctl.advance) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= cordic_type'($signed(residual_v));
         quad_ff[0] <= quad_v;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      cordic_type step_angle;
      logic       rot_pos;

      assign step_angle = cordic_type'(ATAN_TABLE[i]);
      assign rot_pos    = !z_ff[i][CORDIC_WIDTH-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (in_ctl.advance) begin
            if (rot_pos) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - step_angle;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + step_angle;
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[CORDIC_STEPS+1] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[CORDIC_STEPS+1] <= valid_ff[CORDIC_STEPS];
      end
      if (in_ctl.advance) begin
         case (quad_ff[CORDIC_STEPS])
            QUAD_EAST: begin
               cos_ff <= x_ff[CORDIC_STEPS];
               sin_ff <= y_ff[CORDIC_STEPS];
            end
            QUAD_NORTH: begin
               cos_ff <= -y_ff[CORDIC_STEPS];
               sin_ff <= x_ff[CORDIC_STEPS];
            end
            QUAD_WEST: begin
               cos_ff <= -x_ff[CORDIC_STEPS];
               sin_ff <= -y_ff[CORDIC_STEPS];
            end
            QUAD_SOUTH: begin
               cos_ff <= y_ff[CORDIC_STEPS];
               sin_ff <= -x_ff[CORDIC_STEPS];
            end
            default: begin
               cos_ff <= x_ff[CORDIC_STEPS];
               sin_ff <= y_ff[CORDIC_STEPS];
            end
         endcase
      end
   end

   assign sin_value = sin_ff;
   assign cos_value = cos_ff;
   assign out_valid = valid_ff[CORDIC_STEPS+1];

endmodule

`default_nettype wire

/* rtl/core/hdu_sqrt.sv */
// Pipelined integer square root of a 61-bit radicand, one root bit per stage.
// Produces the floor of the root; uses hdu_pkg.
`default_nettype none

module hdu_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  hdu_pkg::stage_ctl_type in_ctl,
   input  logic [60:0]           radicand,
   output logic                  out_valid,
   output hdu_pkg::root_type      root
);
   import hdu_pkg::*;

   localparam int STEPS = ROOT_WIDTH;

   logic [60:0] rem_ff   [0:STEPS];
   root_type    root_ff  [0:STEPS];
   logic        valid_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[0] <= in_ctl.valid;
      end
      if (in_ctl.advance) begin
         rem_ff[0]  <= radicand;
         root_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j <= STEPS; j++) begin : g_bit
      localparam int K = STEPS - j;
      logic [61:0] trial;
      logic [61:0] rem_wide;
      logic        fits;

      assign trial    = ({31'b0, root_ff[j-1]} << (K + 1)) + (62'd1 << (2 * K));
      assign rem_wide = {1'b0, rem_ff[j-1]};
      assign fits     = rem_wide >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         if (in_ctl.advance) begin
            if (fits) begin
               rem_ff[j]  <= 61'(rem_wide - trial);
               root_ff[j] <= root_ff[j-1] | (root_type'(1) << K);
            end else begin
               rem_ff[j]  <= rem_ff[j-1];
               root_ff[j] <= root_ff[j-1];
            end
         end
      end
   end

   assign root      = root_ff[STEPS];
   assign out_valid = valid_ff[STEPS];

endmodule

`default_nettype wire

/* rtl/core/hdu_atan.sv */
// Vectoring CORDIC giving the phase of (den, num), clamped to a quarter turn.
// One micro-rotation per register stage; uses hdu_pkg.
`default_nettype none

module hdu_atan (
   input  logic                  clock,
   input  logic                  reset,
   input  hdu_pkg::stage_ctl_type in_ctl,
   input  hdu_pkg::root_type      num,
   input  hdu_pkg::root_type      den,
   output logic                  out_valid,
   output hdu_pkg::root_type      angle
);
   import hdu_pkg::*;

   cordic_type x_ff     [0:CORDIC_STEPS];
   cordic_type y_ff     [0:CORDIC_STEPS];
   cordic_type z_ff     [0:CORDIC_STEPS];
   logic       valid_ff [0:CORDIC_STEPS+1];
   root_type   angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[0] <= in_ctl.valid;
      end
      if (in_ctl.advance) begin
         x_ff[0] <= cordic_type'(den);
         y_ff[0] <= cordic_type'(num);
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      cordic_type step_angle;
      logic       y_pos;

      assign step_angle = cordic_type'(ATAN_TABLE[i]);
      assign y_pos      = y_ff[i] > cordic_type'(0);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (in_ctl.advance) begin
            if (y_pos) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + step_angle;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - step_angle;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[CORDIC_STEPS+1] <= 1'b0;
      end else if (in_ctl.advance) begin
         valid_ff[CORDIC_STEPS+1] <= valid_ff[CORDIC_STEPS];
      end
      if (in_ctl.advance) begin
         if (z_ff[CORDIC_STEPS][CORDIC_WIDTH-1]) begin
            angle_ff <= '0;
         end else if (z_ff[CORDIC_STEPS] > ONE_Q30) begin
            angle_ff <= UNIT_Q30;
         end else begin
            angle_ff <= z_ff[CORDIC_STEPS][ROOT_WIDTH-1:0];
         end
      end
   end

   assign angle     = angle_ff;
   assign out_valid = valid_ff[CORDIC_STEPS+1];

endmodule

`default_nettype wire

/* rtl/core/haversine_distance_unit.sv */
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall  origin/dest latitude and longitude
// rsp      out        rsp_valid/rsp_stall  rsp_distance_km (km * 256)
//
// One beat is accepted per cycle while req_stall is low; a result passes through
// the period dividers, the 30-step sine and cosine CORDIC pipelines, the root
// pipeline and the 30-step arctangent CORDIC pipeline.
// Reset is synchronous and clears only valid bits; nothing is kept between beats.
// The whole pipeline holds only while a second result waits in the output skid
// register, so req_stall follows one register and a stall loses no beat.
// Top level of the haversine pipeline; uses hdu_pkg, hdu_phase, hdu_sincos,
// hdu_sqrt and hdu_atan.
`default_nettype none

module haversine_distance_unit #(
   parameter int ANGLE_FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_origin_latitude,
   input  logic signed [24:0] req_origin_longitude,
   input  logic signed [23:0] req_dest_latitude,
   input  logic signed [24:0] req_dest_longitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [22:0]        rsp_distance_km
);
   import hdu_pkg::*;

   localparam int          PW         = 2 * CORDIC_WIDTH;
   localparam logic [62:0] DIST_SCALE = 63'd2623418525;
   localparam logic [62:0] DIST_ROUND = 63'd1 << 38;
   localparam logic [23:0] DIST_MAX   = 24'h7FFFFF;

   function automatic cordic_type mul_q30(input cordic_type a, input cordic_type b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      p = p + (PW'(1) <<< 29);
      return cordic_type'(p >>> 30);
   endfunction

   logic advance;
   logic take;

   logic      in_valid_ff;
   angle_type lat1_ff, lat2_ff, dlat_ff, dlon_ff;
   stage_ctl_type in_ctl;

   phase_type ph_lat1, ph_lat2, ph_dlat, ph_dlon;
   logic      ph_valid;
   stage_ctl_type ph_ctl;

   cordic_type cos_lat1, cos_lat2, sin_hlat, sin_hlon;
   logic       sc_valid;

   logic       m1_valid_ff, m2_valid_ff, m3_valid_ff;
   cordic_type sq_lat_ff, cc_ff, sq_lon_ff, sq_lat2_ff, t_ff;
   cordic_type h_sum;
   root_type   h_ff;
   stage_ctl_type m3_ctl;

   root_type root_a, root_b;
   logic     sq_valid;
   stage_ctl_type sq_ctl;

   root_type angle_z;
   logic     at_valid;

   logic        s1_valid_ff;
   logic [62:0] prod_ff;
   logic [62:0] rounded;
   logic [23:0] dist_wide;
   logic [22:0] dist_v;

   logic        rsp_valid_ff;
   logic [22:0] rsp_dist_ff;
   logic        skid_valid_ff;
   logic [22:0] skid_dist_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         lat1_ff <= angle_type'(req_origin_latitude);
         lat2_ff <= angle_type'(req_dest_latitude);
         dlat_ff <= angle_type'(req_origin_latitude) - angle_type'(req_dest_latitude);
         dlon_ff <= angle_type'(req_origin_longitude) - angle_type'(req_dest_longitude);
      end
   end

   always_comb begin
      in_ctl.advance = advance;
      in_ctl.valid   = in_valid_ff;
      ph_ctl.advance = advance;
      ph_ctl.valid   = ph_valid;
      m3_ctl.advance = advance;
      m3_ctl.valid   = m3_valid_ff;
      sq_ctl.advance = advance;
      sq_ctl.valid   = sq_valid;
   end

   hdu_phase #(.FRAC_BITS(ANGLE_FRACTION_BITS), .HALF_ANGLE(1'b0)) u_phase_lat1 (
      .clock(clock), .reset(reset), .in_ctl(in_ctl), .angle(lat1_ff),
      .out_valid(ph_valid), .phase(ph_lat1)
   );
   hdu_phase #(.FRAC_BITS(ANGLE_FRACTION_BITS), .HALF_ANGLE(1'b0)) u_phase_lat2 (
      .clock(clock), .reset(reset), .in_ctl(in_ctl), .angle(lat2_ff),
      .out_valid(), .phase(ph_lat2)
   );
   hdu_phase #(.FRAC_BITS(ANGLE_FRACTION_BITS), .HALF_ANGLE(1'b1)) u_phase_dlat (
      .clock(clock), .reset(reset), .in_ctl(in_ctl), .angle(dlat_ff),
      .out_valid(), .phase(ph_dlat)
   );
   hdu_phase #(.FRAC_BITS(ANGLE_FRACTION_BITS), .HALF_ANGLE(1'b1)) u_phase_dlon (
      .clock(clock), .reset(reset), .in_ctl(in_ctl), .angle(dlon_ff),
      .out_valid(), .phase(ph_dlon)
   );

   hdu_sincos u_sincos_lat1 (
      .clock(clock), .reset(reset), .in_ctl(ph_ctl), .phase(ph_lat1),
      .out_valid(sc_valid), .sin_value(), .cos_value(cos_lat1)
   );
   hdu_sincos u_sincos_lat2 (
      .clock(clock), .reset(reset), .in_ctl(ph_ctl), .phase(ph_lat2),
      .out_valid(), .sin_value(), .cos_value(cos_lat2)
   );
   hdu_sincos u_sincos_dlat (
      .clock(clock), .reset(reset), .in_ctl(ph_ctl), .phase(ph_dlat),
      .out_valid(), .sin_value(sin_hlat), .cos_value()
   );
   hdu_sincos u_sincos_dlon (
      .clock(clock), .reset(reset), .in_ctl(ph_ctl), .phase(ph_dlon),
      .out_valid(), .sin_value(sin_hlon), .cos_value()
   );

   assign h_sum = sq_lat2_ff + t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= sc_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         sq_lat_ff  <= mul_q30(sin_hlat, sin_hlat);
         cc_ff      <= mul_q30(cos_lat1, cos_lat2);
         sq_lon_ff  <= mul_q30(sin_hlon, sin_hlon);
         sq_lat2_ff <= sq_lat_ff;
         t_ff       <= mul_q30(cc_ff, sq_lon_ff);
         if (h_sum[CORDIC_WIDTH-1]) begin
            h_ff <= '0;
         end else if (h_sum > ONE_Q30) begin
            h_ff <= UNIT_Q30;
         end else begin
            h_ff <= h_sum[ROOT_WIDTH-1:0];
         end
      end
   end

   hdu_sqrt u_sqrt_h (
      .clock(clock), .reset(reset), .in_ctl(m3_ctl), .radicand({h_ff, 30'b0}),
      .out_valid(sq_valid), .root(root_a)
   );
   hdu_sqrt u_sqrt_rest (
      .clock(clock), .reset(reset), .in_ctl(m3_ctl), .radicand({UNIT_Q30 - h_ff, 30'b0}),
      .out_valid(), .root(root_b)
   );

   hdu_atan u_atan (
      .clock(clock), .reset(reset), .in_ctl(sq_ctl), .num(root_a), .den(root_b),
      .out_valid(at_valid), .angle(angle_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= at_valid;
      end
      if (advance) begin
         prod_ff <= 63'(angle_z) * DIST_SCALE;
      end
   end

   assign rounded   = prod_ff + DIST_ROUND;
   assign dist_wide = rounded[62:39];
   assign dist_v    = (dist_wide > DIST_MAX) ? DIST_MAX[22:0] : dist_wide[22:0];

   // The skid register catches the beat leaving the pipeline while the output
   // register is stalled; the pipeline holds only while the skid is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         if (s1_valid_ff) begin
            if (rsp_valid_ff && !take) begin
               skid_valid_ff <= 1'b1;
               skid_dist_ff  <= dist_v;
            end else begin
               rsp_valid_ff <= 1'b1;
               rsp_dist_ff  <= dist_v;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (take) begin
         rsp_dist_ff   <= skid_dist_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_km = rsp_dist_ff;

`ifndef SYNTHESIS
   a_skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff && rsp_valid_ff)
      else $error("skid register lost a beat under stall");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && take |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid register did not move to output");

   a_h_clamped: assert property (@(posedge clock) disable iff (reset)
      m3_valid_ff && h_ff[ROOT_WIDTH-1] |-> h_ff[ROOT_WIDTH-2:0] == '0)
      else $error("haversine term above one");
`endif

endmodule

`default_nettype wire
